FILE: src/htw_pkg.sv
package htw_pkg;

   localparam int TIMERS    = 32;
   localparam int SLOTS     = 64;
   localparam int TIME_BITS = 48;
   localparam int ID_BITS   = $clog2(TIMERS);
   localparam int LINK_BITS = $clog2(TIMERS + 1);
   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam int SPAN_BITS = $clog2(SLOTS + 1);
   localparam logic [LINK_BITS-1:0] NIL = LINK_BITS'(TIMERS);

   typedef enum logic [2:0] {
      FUNC_START  = 3'd0,
      FUNC_ALLOC  = 3'd1,
      FUNC_FREE   = 3'd2,
      FUNC_INSERT = 3'd3,
      FUNC_REMOVE = 3'd4,
      FUNC_TICK   = 3'd5
   } func_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [4:0]  timer_id;
      logic [47:0] time_value;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic        granted;
      logic [4:0]  timer_id_out;
      logic [47:0] fire_tick;
      logic        last_of_run;
   } rsp_type;

   // datapath operations, one per controller step
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_CLEAR,
      OP_ALLOC,
      OP_FREE_PUSH,
      OP_UNLINK,
      OP_INSERT,
      OP_TICK_INIT,
      OP_TICK_POP,
      OP_TICK_NEXT,
      OP_TICK_DONE
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic id_ok;
      logic allocated;
      logic linked;
      logic slot_busy;
      logic walk_done;
      logic count_full;
   } sts_type;

endpackage

FILE: src/htw_ctrl.sv
module htw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  htw_pkg::func_type func,
   input  logic             rsp_busy,
   input  htw_pkg::sts_type  sts,
   output htw_pkg::cmd_type  cmd
);
   import htw_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_DECODE = 7'b0000100,
      ST_UNLINK = 7'b0001000,
      ST_FINISH = 7'b0010000,
      ST_WALK   = 7'b0100000,
      ST_POP    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op   = OP_LATCH;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (func)
               FUNC_START: begin
                  cmd.op   = OP_CLEAR;
                  state_in = ST_CLEAR;
               end
               FUNC_ALLOC: begin
                  if (!rsp_busy) begin
                     cmd.op   = OP_ALLOC;
                     state_in = ST_IDLE;
                  end
               end
               FUNC_FREE, FUNC_INSERT: begin
                  if (sts.id_ok && sts.allocated) begin
                     state_in = sts.linked ? ST_UNLINK : ST_FINISH;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               FUNC_REMOVE: begin
                  if (sts.id_ok && sts.linked) cmd.op = OP_UNLINK;
                  state_in = ST_IDLE;
               end
               FUNC_TICK: begin
                  cmd.op   = OP_TICK_INIT;
                  state_in = ST_WALK;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_UNLINK: begin
            cmd.op   = OP_UNLINK;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.op   = (func == FUNC_FREE) ? OP_FREE_PUSH : OP_INSERT;
            state_in = ST_IDLE;
         end
         ST_WALK: begin
            if (sts.walk_done) begin
               if (!rsp_busy) begin
                  cmd.op   = OP_TICK_DONE;
                  state_in = ST_IDLE;
               end
            end else if (sts.slot_busy && !sts.count_full) begin
               state_in = ST_POP;
            end else begin
               cmd.op = OP_TICK_NEXT;
            end
         end
         ST_POP: begin
            if (!rsp_busy) begin
               cmd.op   = OP_TICK_POP;
               state_in = ST_WALK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: src/htw_dp.sv
module htw_dp (
   input  logic             clock,
   input  logic             reset,
   input  htw_pkg::req_type  req_payload,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output htw_pkg::rsp_type  rsp_payload,
   output htw_pkg::func_type func,
   output logic             rsp_busy,
   input  htw_pkg::cmd_type  cmd,
   output htw_pkg::sts_type  sts
);
   import htw_pkg::*;

   logic [LINK_BITS-1:0] slot_head_ff [SLOTS];
   logic [LINK_BITS-1:0] slot_rd_ff;
   logic [LINK_BITS-1:0] next_ff [TIMERS];
   logic [LINK_BITS-1:0] prev_ff [TIMERS];
   logic [TIMERS-1:0]    linked_ff, alloc_ff;
   logic [TIME_BITS-1:0] timeout_ff [TIMERS];
   logic [LINK_BITS-1:0] free_head_ff;
   logic [TIME_BITS-1:0] last_ff;
   logic [TIME_BITS-1:0] tick_ff;
   logic [SPAN_BITS-1:0] span_ff, k_ff;
   logic [LINK_BITS-1:0] count_ff;
   logic [SLOT_BITS:0]   clr_ff;
   req_type              req_ff;
   logic                 pend_ff;
   rsp_type              hold_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic [ID_BITS-1:0]   tid;
   logic                 id_ok;
   logic [LINK_BITS-1:0] un_n, un_p, fh;
   logic [SLOT_BITS-1:0] un_s, ins_s, tick_s;
   logic [LINK_BITS-1:0] ins_h, pop_e, pop_n;
   logic [TIME_BITS-1:0] diff;
   logic [TIME_BITS-1:0] tick_nxt;
   logic                 slot_we;
   logic [SLOT_BITS-1:0] slot_wa, slot_ra;
   logic [LINK_BITS-1:0] slot_wd;
   logic                 rsp_load;
   rsp_type              last_rsp;

   assign tid   = req_ff.timer_id[ID_BITS-1:0];
   assign id_ok = {1'b0, req_ff.timer_id} < 6'(TIMERS);
   assign func  = func_type'(req_ff.func);
   assign un_n  = next_ff[tid];
   assign un_p  = prev_ff[tid];
   assign un_s  = timeout_ff[tid][SLOT_BITS-1:0];
   assign ins_s = req_ff.time_value[SLOT_BITS-1:0];
   assign ins_h = slot_rd_ff;
   assign tick_s = tick_ff[SLOT_BITS-1:0];
   assign pop_e = slot_rd_ff;
   assign pop_n = next_ff[pop_e[ID_BITS-1:0]];
   assign fh    = free_head_ff;
   assign diff  = req_ff.time_value - last_ff;

   assign rsp_busy    = rsp_valid_ff && rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign rsp_load = (cmd.op == OP_ALLOC) ||
                     ((cmd.op == OP_TICK_POP || cmd.op == OP_TICK_DONE) && pend_ff);

   assign sts.clear_done  = clr_ff[SLOT_BITS];
   assign sts.id_ok       = id_ok;
   assign sts.allocated   = alloc_ff[tid];
   assign sts.linked      = linked_ff[tid];
   assign sts.slot_busy   = pop_e != NIL;
   assign sts.walk_done   = k_ff > span_ff;
   assign sts.count_full  = count_ff == LINK_BITS'(TIMERS);

   always_comb begin
      last_rsp             = hold_ff;
      last_rsp.last_of_run = 1'b1;
   end

   always_comb begin
      case (cmd.op)
         OP_TICK_INIT: tick_nxt = last_ff + 1'b1;
         OP_TICK_NEXT: tick_nxt = tick_ff + 1'b1;
         default:      tick_nxt = tick_ff;
      endcase
   end

   // slot table read address is set up ahead of its use, as the table read is registered
   assign slot_ra = (func == FUNC_TICK) ? tick_nxt[SLOT_BITS-1:0] : ins_s;

   always_comb begin
      slot_we = 1'b0;
      slot_wa = clr_ff[SLOT_BITS-1:0];
      slot_wd = NIL;
      case (cmd.op)
         OP_CLEAR: slot_we = 1'b1;
         OP_UNLINK: begin
            slot_we = un_p == NIL;
            slot_wa = un_s;
            slot_wd = un_n;
         end
         OP_INSERT: begin
            slot_we = 1'b1;
            slot_wa = ins_s;
            slot_wd = {1'b0, tid};
         end
         OP_TICK_POP: begin
            slot_we = 1'b1;
            slot_wa = tick_s;
            slot_wd = pop_n;
         end
         default: ;
      endcase
   end

   // slot table with registered read, a write passes through to the read
   always_ff @(posedge clock) begin
      if (slot_we && !reset) slot_head_ff[slot_wa] <= slot_wd;
      if (slot_we && !reset && slot_wa == slot_ra) slot_rd_ff <= slot_wd;
      else slot_rd_ff <= slot_head_ff[slot_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         clr_ff       <= '0;
         last_ff      <= '0;
         free_head_ff <= '0;
         linked_ff    <= '0;
         alloc_ff     <= '0;
         req_ff       <= '0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (cmd.op)
            OP_LATCH: begin
               req_ff <= req_payload;
               clr_ff <= '0;
            end
            OP_CLEAR: begin
               // one slot per cycle, timer arrays reset in the first
               if (!clr_ff[SLOT_BITS]) clr_ff <= clr_ff + 1'b1;
               if (clr_ff == '0) begin
                  for (int i = 0; i < TIMERS; i++) begin
                     next_ff[i] <= LINK_BITS'(i + 1);
                     prev_ff[i] <= NIL;
                  end
                  linked_ff    <= '0;
                  alloc_ff     <= '0;
                  free_head_ff <= '0;
                  last_ff      <= (req_ff.func == 3'(FUNC_START)) ? req_ff.time_value : '0;
               end
            end
            OP_ALLOC: begin
               rsp_ff.result_kind  <= 1'b0;
               rsp_ff.fire_tick    <= '0;
               rsp_ff.last_of_run  <= 1'b1;
               if (fh == NIL) begin
                  rsp_ff.granted      <= 1'b0;
                  rsp_ff.timer_id_out <= '0;
               end else begin
                  rsp_ff.granted      <= 1'b1;
                  rsp_ff.timer_id_out <= 5'(fh);
                  free_head_ff        <= next_ff[fh[ID_BITS-1:0]];
                  next_ff[fh[ID_BITS-1:0]] <= NIL;
                  prev_ff[fh[ID_BITS-1:0]] <= NIL;
                  alloc_ff[fh[ID_BITS-1:0]] <= 1'b1;
               end
            end
            OP_UNLINK: begin
               if (un_n != NIL) prev_ff[un_n[ID_BITS-1:0]] <= un_p;
               if (un_p != NIL) next_ff[un_p[ID_BITS-1:0]] <= un_n;
               next_ff[tid]   <= NIL;
               prev_ff[tid]   <= NIL;
               linked_ff[tid] <= 1'b0;
            end
            OP_FREE_PUSH: begin
               alloc_ff[tid] <= 1'b0;
               next_ff[tid]  <= fh;
               prev_ff[tid]  <= NIL;
               free_head_ff  <= {1'b0, tid};
            end
            OP_INSERT: begin
               timeout_ff[tid] <= req_ff.time_value;
               next_ff[tid]    <= ins_h;
               prev_ff[tid]    <= NIL;
               if (ins_h != NIL) prev_ff[ins_h[ID_BITS-1:0]] <= {1'b0, tid};
               linked_ff[tid]  <= 1'b1;
            end
            OP_TICK_INIT: begin
               count_ff <= '0;
               pend_ff  <= 1'b0;
               k_ff     <= SPAN_BITS'(1);
               tick_ff  <= tick_nxt;
               if (req_ff.time_value <= last_ff) span_ff <= '0;
               else if (diff > TIME_BITS'(SLOTS)) span_ff <= SPAN_BITS'(SLOTS);
               else span_ff <= diff[SPAN_BITS-1:0];
            end
            OP_TICK_NEXT: begin
               k_ff    <= k_ff + 1'b1;
               tick_ff <= tick_nxt;
            end
            OP_TICK_POP: begin
               // one item is held back so that the last can be marked
               if (pop_n != NIL) prev_ff[pop_n[ID_BITS-1:0]] <= NIL;
               next_ff[pop_e[ID_BITS-1:0]] <= NIL;
               prev_ff[pop_e[ID_BITS-1:0]] <= NIL;
               linked_ff[pop_e[ID_BITS-1:0]] <= 1'b0;
               count_ff <= count_ff + 1'b1;
               hold_ff.result_kind  <= 1'b1;
               hold_ff.granted      <= 1'b0;
               hold_ff.timer_id_out <= 5'(pop_e);
               hold_ff.fire_tick    <= tick_ff;
               hold_ff.last_of_run  <= 1'b0;
               pend_ff <= 1'b1;
               if (pend_ff) rsp_ff <= hold_ff;
            end
            OP_TICK_DONE: begin
               last_ff <= req_ff.time_value;
               pend_ff <= 1'b0;
               if (pend_ff) rsp_ff <= last_rsp;
            end
            default: ;
         endcase
      end
   end

endmodule

FILE: src/hashed_timer_wheel.sv
// alloc: answer registered in decode (held while an older result stalls), next item taken back in idle
// free, insert, remove: decode, then unlink and finish as needed, next item taken back in idle, no result
// tick: walks the ticks after the last one (up to SLOTS ticks) and pops the expired items of each
// start: the slot clearing pass, one slot per cycle
// throughput: one item at a time, results waiting on rsp_stall hold the controller
// reset: synchronous, then the slot clearing pass, no item accepted during it
module hashed_timer_wheel (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  htw_pkg::req_type  req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output htw_pkg::rsp_type  rsp_payload
);
   import htw_pkg::*;

   cmd_type  cmd;
   sts_type  sts;
   func_type func;
   logic     rsp_busy;

   htw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .func      (func),
      .rsp_busy  (rsp_busy),
      .sts       (sts),
      .cmd       (cmd)
   );

   htw_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .func        (func),
      .rsp_busy    (rsp_busy),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

FILE: test/tb.sv
module tb;
   import htw_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   hashed_timer_wheel dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   always #1 clock = ~clock;

   // wheel image used for prediction
   int          w_slot[SLOTS];
   int          w_next[TIMERS];
   int          w_prev[TIMERS];
   bit          w_linked[TIMERS];
   bit          w_owned[TIMERS];
   logic [47:0] w_timeout[TIMERS];
   int          w_free;
   logic [47:0] w_last;

   req_type pending_items[$];
   rsp_type expected_rsps[$];
   int      errors = 0;
   bit      quiet = 1'b0;
   bit      hold_rsp = 1'b0;
   bit      hold_req = 1'b0;
   int      req_gap = 0;
   int      rsp_gap = 0;
   int      hold_count = 0;

   function automatic void wheel_clear(logic [47:0] now);
      for (int i = 0; i < TIMERS; i++) begin
         w_next[i] = i + 1;
         w_prev[i] = TIMERS;
         w_linked[i] = 1'b0;
         w_owned[i] = 1'b0;
         w_timeout[i] = '0;
      end
      for (int i = 0; i < SLOTS; i++) w_slot[i] = TIMERS;
      w_free = 0;
      w_last = now;
   endfunction

   function automatic void wheel_unlink(int t);
      int n;
      int p;
      n = w_next[t];
      p = w_prev[t];
      if (n != TIMERS) w_prev[n] = p;
      if (p != TIMERS) w_next[p] = n;
      else w_slot[int'(w_timeout[t] % SLOTS)] = n;
      w_next[t] = TIMERS;
      w_prev[t] = TIMERS;
      w_linked[t] = 1'b0;
   endfunction

   function automatic void push_rsp(bit kind, bit gr, int id, logic [47:0] tick);
      rsp_type r;
      r.result_kind = kind;
      r.granted = gr;
      r.timer_id_out = 5'(id);
      r.fire_tick = tick;
      r.last_of_run = 1'b0;
      expected_rsps.push_back(r);
   endfunction

   function automatic void wheel_apply(req_type it);
      int t;
      int cnt;
      int s;
      int e;
      int g;
      logic [47:0] span;
      logic [47:0] tick;
      t = int'(it.timer_id);
      cnt = 0;
      case (func_type'(it.func))
         FUNC_START: wheel_clear(it.time_value);
         FUNC_ALLOC: begin
            if (w_free == TIMERS) push_rsp(1'b0, 1'b0, 0, '0);
            else begin
               g = w_free;
               w_free = w_next[g];
               w_next[g] = TIMERS;
               w_prev[g] = TIMERS;
               w_owned[g] = 1'b1;
               push_rsp(1'b0, 1'b1, g, '0);
            end
            cnt = 1;
         end
         FUNC_FREE: if (w_owned[t]) begin
            if (w_linked[t]) wheel_unlink(t);
            w_owned[t] = 1'b0;
            w_next[t] = w_free;
            w_prev[t] = TIMERS;
            w_free = t;
         end
         FUNC_INSERT: if (w_owned[t]) begin
            if (w_linked[t]) wheel_unlink(t);
            w_timeout[t] = it.time_value;
            s = int'(it.time_value % SLOTS);
            w_next[t] = w_slot[s];
            w_prev[t] = TIMERS;
            if (w_slot[s] != TIMERS) w_prev[w_slot[s]] = t;
            w_slot[s] = t;
            w_linked[t] = 1'b1;
         end
         FUNC_REMOVE: if (w_linked[t]) wheel_unlink(t);
         FUNC_TICK: begin
            if (it.time_value > w_last) begin
               span = it.time_value - w_last;
               if (span > SLOTS) span = 48'(SLOTS);
               for (int k = 1; k <= span; k++) begin
                  tick = w_last + 48'(k);
                  s = int'(tick % SLOTS);
                  while (w_slot[s] != TIMERS && cnt < TIMERS) begin
                     e = w_slot[s];
                     if (w_next[e] != TIMERS) w_prev[w_next[e]] = TIMERS;
                     w_slot[s] = w_next[e];
                     w_next[e] = TIMERS;
                     w_prev[e] = TIMERS;
                     w_linked[e] = 1'b0;
                     push_rsp(1'b1, 1'b0, e, tick);
                     cnt++;
                  end
               end
            end
            w_last = it.time_value;
         end
         default: ;
      endcase
      if (cnt > 0) expected_rsps[$].last_of_run = 1'b1;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_stall) begin
         wheel_apply(req_payload);
         if (req_gap == 0 && !quiet && $urandom_range(0, 9) == 0)
            req_gap = $urandom_range(1, 7);
         if (req_gap > 0 || hold_req || pending_items.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            req_payload <= pending_items.pop_front();
         end
      end else if (!req_valid) begin
         if (req_gap > 0) req_gap--;
         if (req_gap == 0 && !hold_req && pending_items.size() > 0) begin
            req_valid <= 1'b1;
            req_payload <= pending_items.pop_front();
         end
      end
   end

   // receiver stall and result check
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected item: timer_id_out %0d", rsp_payload.timer_id_out);
               errors++;
            end else begin
               rsp_type x;
               x = expected_rsps.pop_front();
               if (x.result_kind !== rsp_payload.result_kind) begin
                  $error("result_kind: expected %0d actual %0d",
                         x.result_kind, rsp_payload.result_kind);
                  errors++;
               end
               if (x.granted !== rsp_payload.granted) begin
                  $error("granted: expected %0d actual %0d", x.granted, rsp_payload.granted);
                  errors++;
               end
               if (x.timer_id_out !== rsp_payload.timer_id_out) begin
                  $error("timer_id_out: expected %0d actual %0d",
                         x.timer_id_out, rsp_payload.timer_id_out);
                  errors++;
               end
               if (x.fire_tick !== rsp_payload.fire_tick) begin
                  $error("fire_tick: expected %0h actual %0h", x.fire_tick, rsp_payload.fire_tick);
                  errors++;
               end
               if (x.last_of_run !== rsp_payload.last_of_run) begin
                  $error("last_of_run: expected %0d actual %0d",
                         x.last_of_run, rsp_payload.last_of_run);
                  errors++;
               end
            end
         end
         if (hold_count > 0) begin
            hold_count--;
            rsp_stall <= 1'b1;
         end else if (hold_rsp) begin
            hold_count = 400;
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(0, 6);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic req_type make_item(func_type f, int id, logic [47:0] tv);
      req_type r;
      r.func = f;
      r.timer_id = 5'(id);
      r.time_value = tv;
      return r;
   endfunction

   function automatic logic [47:0] rand48();
      return {16'($urandom), $urandom};
   endfunction

   // scenario pools, kept in step with the order of items queued
   task automatic add_random_phase(int n, logic [47:0] base);
      logic [47:0] now;
      int r;
      now = base;
      pending_items.push_back(make_item(FUNC_START, $urandom_range(0, 31), now));
      for (int i = 0; i < 6; i++) pending_items.push_back(make_item(FUNC_ALLOC, 0, '0));
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 15)
            pending_items.push_back(make_item(FUNC_ALLOC, $urandom_range(0, 31), rand48()));
         else if (r < 45)
            pending_items.push_back(make_item(FUNC_INSERT, $urandom_range(0, 15),
                                              now + $urandom_range(1, 80)));
         else if (r < 52)
            pending_items.push_back(make_item(FUNC_REMOVE, $urandom_range(0, 31), rand48()));
         else if (r < 60)
            pending_items.push_back(make_item(FUNC_FREE, $urandom_range(0, 31), rand48()));
         else if (r < 90) begin
            now = now + $urandom_range(0, 20);
            pending_items.push_back(make_item(FUNC_TICK, $urandom_range(0, 31), now));
         end else if (r < 93) begin
            // stale tick, nothing fires
            pending_items.push_back(make_item(FUNC_TICK, 0, now - $urandom_range(0, 3)));
            pending_items.push_back(make_item(FUNC_TICK, 0, now));
         end else if (r < 96) begin
            now = now + $urandom_range(65, 300);
            pending_items.push_back(make_item(FUNC_TICK, 0, now));
         end else begin
            pending_items.push_back(make_item(func_type'(3'($urandom_range(6, 7))),
                                              $urandom_range(0, 31), rand48()));
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   initial begin
      wheel_clear('0);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (SLOTS + 10) @(posedge clock);
      // directed: pool exhaustion, extremes, relinks, long gap
      for (int i = 0; i < 33; i++) begin
         if (i == 0) pending_items.push_back(make_item(FUNC_START, 31, 48'hFFFF_FFFF_FF00));
         if (i < 2) pending_items.push_back(make_item(FUNC_ALLOC, 0, '0));
      end
      pending_items.push_back(make_item(FUNC_INSERT, 0, 48'hFFFF_FFFF_FF05));
      pending_items.push_back(make_item(FUNC_INSERT, 1, 48'hFFFF_FFFF_FF05));
      pending_items.push_back(make_item(FUNC_INSERT, 0, 48'hFFFF_FFFF_FF45));
      pending_items.push_back(make_item(FUNC_INSERT, 31, 48'hFFFF_FFFF_FF06));
      pending_items.push_back(make_item(FUNC_REMOVE, 5, '0));
      pending_items.push_back(make_item(FUNC_FREE, 9, '0));
      pending_items.push_back(make_item(FUNC_TICK, 0, 48'hFFFF_FFFF_FFFF));
      pending_items.push_back(make_item(FUNC_TICK, 0, 48'hFFFF_FFFF_FFF0));
      pending_items.push_back(make_item(FUNC_FREE, 1, '0));
      pending_items.push_back(make_item(FUNC_START, 0, '0));
      for (int i = 0; i < 33; i++) pending_items.push_back(make_item(FUNC_ALLOC, 31, '1));
      pending_items.push_back(make_item(FUNC_REMOVE, 0, '0));
      wait_drained();
      add_random_phase(100, rand48() >> 1);
      // long receiver hold while items keep coming
      hold_rsp = 1'b1;
      wait_drained();
      // sender paused while the next phase is queued, then released
      hold_req = 1'b1;
      add_random_phase(100, '0);
      repeat (20) @(posedge clock);
      hold_req = 1'b0;
      wait_drained();
      quiet = 1'b1;
      add_random_phase(60, 48'hFFFF_FFFF_FE00);
      wait_drained();
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end
endmodule

FILE: filelist.f
src/htw_pkg.sv
src/htw_ctrl.sv
src/htw_dp.sv
src/hashed_timer_wheel.sv
test/tb.sv
